// ===== hw/rtl/ipv4_dotted_port_parser_unit_macros.svh =====
// Assertion macros used by the top level of the address parser.
`ifndef IPV4_DOTTED_PORT_PARSER_UNIT_MACROS_SVH
`define IPV4_DOTTED_PORT_PARSER_UNIT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define IDP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define IDP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/idp_pkg.sv =====
// Types and constants shared by the address parser modules.
package idp_pkg;

  // ASCII codes that steer the parse.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [7:0] OCTET_MAX = 8'd255;
  localparam logic [1:0] LAST_IDX  = 2'd3;
  localparam logic [2:0] DOTS_FULL = 3'd3;
  localparam logic [2:0] DOTS_SAT  = 3'd4;

  // Status codes of a result.
  localparam logic [1:0] ST_FIRST_BAD = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_VALID     = 2'd2;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_ADDR  = 2'd1,
    PH_PORT  = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  octet_a;
    logic [7:0]  octet_b;
    logic [7:0]  octet_c;
    logic [7:0]  octet_d;
    logic [15:0] port_number;
  } out_t;

  typedef struct packed {
    phase_t          phase;
    logic [3:0][7:0] octets;
    logic [1:0]      idx;
    logic [2:0]      dots;
    logic [15:0]     port;
    logic            first_bad;
  } state_t;

endpackage

// ===== hw/rtl/ipv4_dotted_port_parser_unit.sv =====
// Top level of the dotted address and port parser.
//
//  Channel  Direction  Handshake                 Carries
//  in_      input      in_valid / in_ready       one character and its last mark
//  out_     output     out_valid / out_ready     status, four octets and the port
//
// Each character is captured in an input register and from there passes
// through the per-character step logic, which updates the parse state and, for
// the last character of a string, loads the result register. One character is
// taken per cycle while no last character waits on a stalled result.
// The rate is set by the single step of the parse state, which every character
// must pass in order. A stalled result holds back only the last character of
// the next string; characters before it keep flowing. Reset is synchronous and
// leaves the parser at the start of a string with both registers empty.
`include "ipv4_dotted_port_parser_unit_macros.svh"

module ipv4_dotted_port_parser_unit
  import idp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // Input register stage.
  logic   in_valid_r;
  in_t    in_r;

  // Parse state, carried from one character to the next.
  state_t state_r;
  state_t state_nxt;

  // Result register stage.
  logic   out_valid_r;
  out_t   out_r;
  out_t   res_nxt;

  logic   adv;

  // The held character moves on unless it would produce a result while the
  // result register is still occupied and not being drained.
  assign adv      = in_valid_r && (!in_r.last_char || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  idp_step u_step (
    .cur  (state_r),
    .item (in_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase     <= PH_START;
      state_r.octets    <= '0;
      state_r.idx       <= '0;
      state_r.dots      <= '0;
      state_r.port      <= '0;
      state_r.first_bad <= 1'b0;
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && in_r.last_char) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_r.last_char) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A processed last character always leaves a result waiting.
  `IDP_ASSERT_NEXT(a_last_loads_result, adv && in_r.last_char, out_valid_r, "last character lost its result")
  // After a result the parser is back at the start of a string.
  `IDP_ASSERT_NEXT(a_last_restarts, adv && in_r.last_char, state_r.phase == PH_START, "parse did not restart")
  // A bad first character reports all fields as zero.
  `IDP_ASSERT_NOW(a_first_bad_zero, out_valid_r && (out_r.status == ST_FIRST_BAD), (out_r.octet_a == 8'd0) && (out_r.octet_b == 8'd0) && (out_r.octet_c == 8'd0) && (out_r.octet_d == 8'd0) && (out_r.port_number == 16'd0), "bad first character with data")
  // The dot count saturates.
  `IDP_ASSERT_NOW(a_dots_saturate, 1'b1, state_r.dots <= DOTS_SAT, "dot count overran")

endmodule

// ===== hw/rtl/idp_step.sv =====
// Per-character next-state and result logic of the address parser.
module idp_step
  import idp_pkg::*;
(
  input  state_t cur,
  input  in_t    item,
  output state_t nxt,
  output out_t   res
);

  logic       digit;
  logic [7:0] dval;
  phase_t     ph;
  state_t     s;
  logic       below_max;

  always_comb begin
    digit = (item.char_in >= CH_ZERO) && (item.char_in <= CH_NINE);
    dval  = item.char_in - CH_ZERO;
    s     = cur;
    ph    = cur.phase;

    // A new string starts from a clean slate.
    if (ph == PH_START) begin
      s.octets    = '0;
      s.idx       = '0;
      s.dots      = '0;
      s.port      = '0;
      s.first_bad = 1'b0;
      if (digit) begin
        ph = PH_ADDR;
      end else begin
        s.first_bad = 1'b1;
        ph          = PH_DONE;
      end
    end

    unique case (ph)
      PH_ADDR: begin
        if (digit) begin
          s.octets[s.idx] = (s.octets[s.idx] << 3) + (s.octets[s.idx] << 1) + dval;
        end else if (item.char_in == CH_DOT) begin
          if (s.idx != LAST_IDX) begin
            s.idx = s.idx + 2'd1;
          end
          if (s.dots != DOTS_SAT) begin
            s.dots = s.dots + 3'd1;
          end
          s.octets[s.idx] = '0;
        end else if (item.char_in == CH_COLON) begin
          ph = PH_PORT;
        end else begin
          ph = PH_DONE;
        end
      end
      PH_PORT: begin
        if (digit) begin
          s.port = (s.port << 3) + (s.port << 1) + {8'd0, dval};
        end else begin
          ph = PH_DONE;
        end
      end
      default: begin
      end
    endcase

    if (item.last_char) begin
      ph = PH_START;
    end
    s.phase = ph;
    nxt     = s;

    below_max = (s.octets[0] != OCTET_MAX) && (s.octets[1] != OCTET_MAX) &&
                (s.octets[2] != OCTET_MAX) && (s.octets[3] != OCTET_MAX);
    if (s.first_bad) begin
      res.status = ST_FIRST_BAD;
    end else if (below_max && (s.dots == DOTS_FULL)) begin
      res.status = ST_VALID;
    end else begin
      res.status = ST_MALFORMED;
    end
    res.octet_a     = s.octets[0];
    res.octet_b     = s.octets[1];
    res.octet_c     = s.octets[2];
    res.octet_d     = s.octets[3];
    res.port_number = s.port;
  end

endmodule
